// File: rtl/core/spe_pkg.sv
// Shared types and constants of the stream prefetch engine.
package spe_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned LINE_BITS_DEF     = 6;
  localparam int unsigned PAGE_BITS_DEF     = 12;
  localparam int unsigned ADDR_BITS_DEF     = 48;

  localparam int unsigned STAMP_W   = 64;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned LOOK_W    = 8;
  localparam int unsigned Q_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CROSS = 2'd2;

  localparam logic [CFG_W-1:0] DIST_RST  = 8'd8;
  localparam logic [CFG_W-1:0] DEG_RST   = 8'd10;
  localparam logic             CROSS_RST = 1'b0;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  typedef enum logic [1:0] {
    KIND_NOP,
    KIND_TICK,
    KIND_TRAIN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic      issue_ok;
    logic      fill;
  } cmd_flags_t;

endpackage

// File: rtl/core/stream_prefetch_engine.sv
// Top level of the stream prefetch engine.
//
//   Channel  Handshake            Payload
//   input    push / full          func_i, access_addr_i, cache_hit_i, issue_ok_i,
//                                 mshr_below_half_i
//   result   empty / pop          prefetch_valid_o, prefetch_addr_o,
//                                 fill_this_level_o, lookahead_busy_o
//   config   cfg_we_i (no wait)   cfg_idx_i, cfg_wdata_i
//
// The back part retires a tick or a cache hit from its idle state. A training miss
// first scans the region table through its single read port, then runs the update
// and insert steps. Reset clears the table valid bits at once; no clearing pass is needed.
// Two-entry queues at the input and the output let each side stall on its own.
module stream_prefetch_engine #(
  parameter int unsigned TABLE_ENTRIES = spe_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned LINE_BITS     = spe_pkg::LINE_BITS_DEF,
  parameter int unsigned PAGE_BITS     = spe_pkg::PAGE_BITS_DEF,
  parameter int unsigned ADDR_BITS     = spe_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spe_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spe_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          func_i,
  input  logic [ADDR_BITS-1:0]          access_addr_i,
  input  logic                          cache_hit_i,
  input  logic                          issue_ok_i,
  input  logic                          mshr_below_half_i,
  output logic                          empty,
  input  logic                          pop,
  output logic                          prefetch_valid_o,
  output logic [ADDR_BITS-1:0]          prefetch_addr_o,
  output logic                          fill_this_level_o,
  output logic                          lookahead_busy_o
);

  localparam int unsigned LW = ADDR_BITS - LINE_BITS;
  localparam int unsigned RW = ADDR_BITS + 3;

  logic                 cmd_valid, cmd_pop;
  logic [LW-1:0]        cmd_line;
  spe_pkg::cmd_flags_t  cmd_flags;
  logic                 res_full, res_push, res_valid, res_fill, res_busy;
  logic [ADDR_BITS-1:0] res_addr;
  logic [RW-1:0]        res_wdata, res_rdata;

  spe_front #(
    .ADDR_BITS(ADDR_BITS),
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .func_i           (func_i),
    .access_addr_i    (access_addr_i),
    .cache_hit_i      (cache_hit_i),
    .issue_ok_i       (issue_ok_i),
    .mshr_below_half_i(mshr_below_half_i),
    .cmd_valid_o      (cmd_valid),
    .cmd_line_o       (cmd_line),
    .cmd_flags_o      (cmd_flags),
    .cmd_pop_i        (cmd_pop)
  );

  spe_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .LINE_BITS    (LINE_BITS),
    .PAGE_BITS    (PAGE_BITS),
    .ADDR_BITS    (ADDR_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_valid_i(cmd_valid),
    .cmd_line_i (cmd_line),
    .cmd_flags_i(cmd_flags),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_valid_o(res_valid),
    .res_addr_o (res_addr),
    .res_fill_o (res_fill),
    .res_busy_o (res_busy)
  );

  assign res_wdata = {res_valid, res_fill, res_busy, res_addr};

  spe_fifo #(
    .WIDTH(RW),
    .DEPTH(spe_pkg::Q_DEPTH)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_wdata),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_rdata),
    .empty_o(empty)
  );

  assign prefetch_valid_o  = res_rdata[RW-1];
  assign fill_this_level_o = res_rdata[RW-2];
  assign lookahead_busy_o  = res_rdata[RW-3];
  assign prefetch_addr_o   = res_rdata[ADDR_BITS-1:0];

endmodule

// File: rtl/core/spe_fifo.sv
// Small show-ahead queue used for the command and result queues of the engine.
module spe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = spe_pkg::Q_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// File: rtl/core/spe_front.sv
// Front part: takes input items, classifies them and queues commands.
module spe_front #(
  parameter int unsigned ADDR_BITS = spe_pkg::ADDR_BITS_DEF,
  parameter int unsigned LINE_BITS = spe_pkg::LINE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic                           func_i,
  input  logic [ADDR_BITS-1:0]           access_addr_i,
  input  logic                           cache_hit_i,
  input  logic                           issue_ok_i,
  input  logic                           mshr_below_half_i,
  output logic                           cmd_valid_o,
  output logic [ADDR_BITS-LINE_BITS-1:0] cmd_line_o,
  output spe_pkg::cmd_flags_t            cmd_flags_o,
  input  logic                           cmd_pop_i
);

  localparam int unsigned LW = ADDR_BITS - LINE_BITS;
  localparam int unsigned FW = $bits(spe_pkg::cmd_flags_t);

  spe_pkg::cmd_flags_t flags;
  logic [LW+FW-1:0]    wdata, rdata;
  logic                empty;

  always_comb begin
    flags.issue_ok = issue_ok_i;
    flags.fill     = mshr_below_half_i;
    if (func_i) begin
      flags.kind = spe_pkg::KIND_TICK;
    end else if (cache_hit_i) begin
      flags.kind = spe_pkg::KIND_NOP;
    end else begin
      flags.kind = spe_pkg::KIND_TRAIN;
    end
  end

  assign wdata = {access_addr_i[ADDR_BITS-1:LINE_BITS], flags};

  spe_fifo #(
    .WIDTH(LW + FW),
    .DEPTH(spe_pkg::Q_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (wdata),
    .full_o (full),
    .pop_i  (cmd_pop_i),
    .data_o (rdata),
    .empty_o(empty)
  );

  assign cmd_valid_o = !empty;
  assign cmd_line_o  = rdata[LW+FW-1:FW];
  assign cmd_flags_o = spe_pkg::cmd_flags_t'(rdata[FW-1:0]);

endmodule

// File: rtl/core/spe_rtab.sv
// Region table memory with per-entry valid bits and registered read.
module spe_rtab #(
  parameter int unsigned ENTRIES = spe_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned LW      = spe_pkg::ADDR_BITS_DEF - spe_pkg::LINE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_idx_i,
  output logic [LW-1:0]               rd_start_o,
  output logic [1:0]                  rd_dir_o,
  output logic [spe_pkg::STAMP_W-1:0] rd_stamp_o,
  input  logic                        we_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] wr_idx_i,
  input  logic [LW-1:0]               wr_start_i,
  input  logic [1:0]                  wr_dir_i,
  input  logic [spe_pkg::STAMP_W-1:0] wr_stamp_i
);

  logic [LW-1:0]               start_mem [ENTRIES];
  logic [1:0]                  dir_mem   [ENTRIES];
  logic [spe_pkg::STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [ENTRIES-1:0]          valid_q;
  logic                        rvalid_q;
  logic [LW-1:0]               rstart_q;
  logic [1:0]                  rdir_q;
  logic [spe_pkg::STAMP_W-1:0] rstamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[rd_idx_i];
      if (we_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rstart_q <= start_mem[rd_idx_i];
    rdir_q   <= dir_mem[rd_idx_i];
    rstamp_q <= stamp_mem[rd_idx_i];
    if (we_i) begin
      start_mem[wr_idx_i] <= wr_start_i;
      dir_mem[wr_idx_i]   <= wr_dir_i;
      stamp_mem[wr_idx_i] <= wr_stamp_i;
    end
  end

  assign rd_start_o = rvalid_q ? rstart_q : '0;
  assign rd_dir_o   = rvalid_q ? rdir_q : spe_pkg::DIR_NONE;
  assign rd_stamp_o = rvalid_q ? rstamp_q : '0;

endmodule

// File: rtl/core/spe_back.sv
// Back part: table scan, training, lookahead and prefetch issue.
module spe_back #(
  parameter int unsigned TABLE_ENTRIES = spe_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned LINE_BITS     = spe_pkg::LINE_BITS_DEF,
  parameter int unsigned PAGE_BITS     = spe_pkg::PAGE_BITS_DEF,
  parameter int unsigned ADDR_BITS     = spe_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spe_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            cmd_valid_i,
  input  logic [ADDR_BITS-LINE_BITS-1:0]  cmd_line_i,
  input  spe_pkg::cmd_flags_t             cmd_flags_i,
  output logic                            cmd_pop_o,
  input  logic                            res_full_i,
  output logic                            res_push_o,
  output logic                            res_valid_o,
  output logic [ADDR_BITS-1:0]            res_addr_o,
  output logic                            res_fill_o,
  output logic                            res_busy_o
);

  localparam int unsigned LW = ADDR_BITS - LINE_BITS;
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SW = spe_pkg::STAMP_W;
  localparam int unsigned KW = spe_pkg::CFG_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_INS  = 2'd3;

  logic [1:0]                state_q, state_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      pend_q, pend_d;
  logic [IW-1:0]             eval_q, eval_d;
  logic                      found_q, found_d;
  logic [IW-1:0]             hit_idx_q, hit_idx_d;
  logic [LW-1:0]             hit_start_q, hit_start_d;
  logic [1:0]                hit_dir_q, hit_dir_d;
  logic [IW-1:0]             best_q, best_d;
  logic [SW-1:0]             best_stamp_q, best_stamp_d;
  logic [SW-1:0]             use_cnt_q, use_cnt_d;
  logic [LW-1:0]             last_line_q, last_line_d;
  logic signed [LW:0]        last_delta_q, last_delta_d;
  logic [1:0]                last_dir_q, last_dir_d;
  logic signed [LW:0]        delta_q, delta_d;
  logic signed [LW+1:0]      span_q, span_d;
  logic [ADDR_BITS-1:0]      look_addr_q, look_addr_d;
  logic [1:0]                look_dir_q, look_dir_d;
  logic [spe_pkg::LOOK_W-1:0] look_left_q, look_left_d;
  logic [KW-1:0]             dist_q, dist_d, deg_q, deg_d;
  logic                      cross_q, cross_d;

  logic [LW-1:0]             rd_start;
  logic [1:0]                rd_dir;
  logic [SW-1:0]             rd_stamp;
  logic                      we;
  logic [IW-1:0]             wr_idx;
  logic [LW-1:0]             wr_start;
  logic [1:0]                wr_dir;
  logic [SW-1:0]             wr_stamp;

  logic [LW:0]               s_ext, dist_ext, line_ext;
  logic                      m_up, m_dn, first, take;
  logic [SW-1:0]             eff;
  logic [ADDR_BITS-1:0]      pf, line_step;
  logic                      pf_ok;
  logic [1:0]                ndir;
  logic signed [LW+1:0]      dist_s;
  logic signed [LW+2:0]      dn_sum;
  logic                      ins;
  logic [LW-1:0]             ins_start, hit_end;
  logic                      go;

  spe_rtab #(
    .ENTRIES(TABLE_ENTRIES),
    .LW     (LW)
  ) u_rtab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (cnt_q[IW-1:0]),
    .rd_start_o(rd_start),
    .rd_dir_o  (rd_dir),
    .rd_stamp_o(rd_stamp),
    .we_i      (we),
    .wr_idx_i  (wr_idx),
    .wr_start_i(wr_start),
    .wr_dir_i  (wr_dir),
    .wr_stamp_i(wr_stamp)
  );

  assign s_ext    = {1'b0, rd_start};
  assign dist_ext = {{(LW+1-KW){1'b0}}, dist_q};
  assign line_ext = {1'b0, cmd_line_i};
  assign m_up = (rd_dir == spe_pkg::DIR_UP) && (rd_start <= cmd_line_i) &&
                (line_ext < s_ext + dist_ext);
  assign m_dn = (rd_dir == spe_pkg::DIR_DOWN) && (s_ext >= dist_ext) &&
                (rd_start >= cmd_line_i) && (line_ext > s_ext - dist_ext);
  assign first = pend_q && (m_up || m_dn) && !found_q;
  assign eff   = first ? use_cnt_q + SW'(1) : rd_stamp;
  assign take  = (eval_q == '0) || (eff == '0) || (eff < best_stamp_q);

  assign line_step = ADDR_BITS'(1) << LINE_BITS;
  always_comb begin
    case (look_dir_q)
      spe_pkg::DIR_UP:   pf = look_addr_q + line_step;
      spe_pkg::DIR_DOWN: pf = look_addr_q - line_step;
      default:           pf = look_addr_q;
    endcase
  end
  assign pf_ok = cross_q || (pf[ADDR_BITS-1:PAGE_BITS] == look_addr_q[ADDR_BITS-1:PAGE_BITS]);

  assign ndir = (delta_q > 0) ? spe_pkg::DIR_UP :
                ((delta_q < 0) ? spe_pkg::DIR_DOWN : spe_pkg::DIR_NONE);
  assign dist_s    = $signed({{(LW+2-KW){1'b0}}, dist_q});
  assign dn_sum    = $signed({span_q[LW+1], span_q}) + $signed({1'b0, dist_s});
  assign ins = ((ndir == spe_pkg::DIR_UP) && (last_dir_q == spe_pkg::DIR_UP) &&
                (span_q < dist_s)) ||
               ((ndir == spe_pkg::DIR_DOWN) && (last_dir_q == spe_pkg::DIR_DOWN) &&
                (dn_sum > 0));
  assign ins_start = cmd_line_i - span_q[LW-1:0];
  assign hit_end   = (hit_dir_q == spe_pkg::DIR_UP) ?
                     hit_start_q + LW'(dist_q) : hit_start_q - LW'(dist_q);

  assign go = cmd_valid_i && !res_full_i;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pend_d       = (state_q == ST_SCAN) && (cnt_q != CW'(TABLE_ENTRIES));
    eval_d       = cnt_q[IW-1:0];
    found_d      = found_q;
    hit_idx_d    = hit_idx_q;
    hit_start_d  = hit_start_q;
    hit_dir_d    = hit_dir_q;
    best_d       = best_q;
    best_stamp_d = best_stamp_q;
    use_cnt_d    = use_cnt_q;
    last_line_d  = last_line_q;
    last_delta_d = last_delta_q;
    last_dir_d   = last_dir_q;
    delta_d      = delta_q;
    span_d       = span_q;
    look_addr_d  = look_addr_q;
    look_dir_d   = look_dir_q;
    look_left_d  = look_left_q;
    dist_d       = dist_q;
    deg_d        = deg_q;
    cross_d      = cross_q;
    we           = 1'b0;
    wr_idx       = hit_idx_q;
    wr_start     = hit_start_q;
    wr_dir       = hit_dir_q;
    wr_stamp     = use_cnt_q + SW'(1);
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    res_valid_o  = 1'b0;
    res_addr_o   = '0;
    res_fill_o   = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        spe_pkg::CFG_DIST:  dist_d  = cfg_wdata_i;
        spe_pkg::CFG_DEG:   deg_d   = cfg_wdata_i;
        spe_pkg::CFG_CROSS: cross_d = cfg_wdata_i[0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (go) begin
          case (cmd_flags_i.kind)
            spe_pkg::KIND_TICK: begin
              res_push_o = 1'b1;
              cmd_pop_o  = 1'b1;
              if (look_left_q != '0) begin
                if (pf_ok) begin
                  res_valid_o = 1'b1;
                  res_addr_o  = pf;
                  res_fill_o  = cmd_flags_i.fill;
                  if (cmd_flags_i.issue_ok) begin
                    look_addr_d = pf;
                    look_left_d = look_left_q - spe_pkg::LOOK_W'(1);
                  end
                end else begin
                  look_left_d = '0;
                end
              end
            end
            spe_pkg::KIND_TRAIN: begin
              state_d = ST_SCAN;
              cnt_d   = '0;
              found_d = 1'b0;
              delta_d = $signed({1'b0, cmd_line_i}) - $signed({1'b0, last_line_q});
            end
            default: begin
              res_push_o = 1'b1;
              cmd_pop_o  = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_q != CW'(TABLE_ENTRIES)) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (pend_q) begin
          if (first) begin
            found_d     = 1'b1;
            hit_idx_d   = eval_q;
            hit_start_d = rd_start;
            hit_dir_d   = rd_dir;
          end
          if (take) begin
            best_d       = eval_q;
            best_stamp_d = eff;
          end
          if (eval_q == IW'(TABLE_ENTRIES - 1)) begin
            state_d = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        span_d  = $signed({delta_q[LW], delta_q}) + $signed({last_delta_q[LW], last_delta_q});
        state_d = ST_INS;
        if (found_q) begin
          we          = 1'b1;
          wr_start    = (hit_dir_q == spe_pkg::DIR_UP) ?
                        hit_start_q + LW'(deg_q) : hit_start_q - LW'(deg_q);
          use_cnt_d   = use_cnt_q + SW'(1);
          look_addr_d = {hit_end, {LINE_BITS{1'b0}}};
          look_dir_d  = hit_dir_q;
          look_left_d = deg_q;
        end
      end
      default: begin
        if (!res_full_i) begin
          if (ins) begin
            we        = 1'b1;
            wr_idx    = best_q;
            wr_start  = ins_start;
            wr_dir    = ndir;
            use_cnt_d = use_cnt_q + SW'(1);
          end
          last_line_d  = cmd_line_i;
          last_dir_d   = ndir;
          last_delta_d = delta_q;
          res_push_o   = 1'b1;
          cmd_pop_o    = 1'b1;
          state_d      = ST_IDLE;
        end
      end
    endcase
  end

  assign res_busy_o = (look_left_d != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      pend_q       <= 1'b0;
      eval_q       <= '0;
      found_q      <= 1'b0;
      hit_idx_q    <= '0;
      hit_start_q  <= '0;
      hit_dir_q    <= spe_pkg::DIR_NONE;
      best_q       <= '0;
      best_stamp_q <= '0;
      use_cnt_q    <= '0;
      last_line_q  <= '0;
      last_delta_q <= '0;
      last_dir_q   <= spe_pkg::DIR_NONE;
      delta_q      <= '0;
      span_q       <= '0;
      look_addr_q  <= '0;
      look_dir_q   <= spe_pkg::DIR_NONE;
      look_left_q  <= '0;
      dist_q       <= spe_pkg::DIST_RST;
      deg_q        <= spe_pkg::DEG_RST;
      cross_q      <= spe_pkg::CROSS_RST;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      pend_q       <= pend_d;
      eval_q       <= eval_d;
      found_q      <= found_d;
      hit_idx_q    <= hit_idx_d;
      hit_start_q  <= hit_start_d;
      hit_dir_q    <= hit_dir_d;
      best_q       <= best_d;
      best_stamp_q <= best_stamp_d;
      use_cnt_q    <= use_cnt_d;
      last_line_q  <= last_line_d;
      last_delta_q <= last_delta_d;
      last_dir_q   <= last_dir_d;
      delta_q      <= delta_d;
      span_q       <= span_d;
      look_addr_q  <= look_addr_d;
      look_dir_q   <= look_dir_d;
      look_left_q  <= look_left_d;
      dist_q       <= dist_d;
      deg_q        <= deg_d;
      cross_q      <= cross_d;
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("Result pushed into a full queue.");

  a_pop_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o == res_push_o)
    else $error("Command retired without exactly one result.");

  a_busy_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> cmd_valid_i)
    else $error("Training in progress without a command at the queue head.");

  a_write_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_UPD || state_q == ST_INS))
    else $error("Table written outside the update steps.");

endmodule

// File: sim/stream_prefetch_engine_tb.sv
// Testbench of the stream prefetch engine: directed and random streams with a self-checking scoreboard.
module stream_prefetch_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NREG  = spe_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned LB    = spe_pkg::LINE_BITS_DEF;
  localparam int unsigned PB    = spe_pkg::PAGE_BITS_DEF;
  localparam int unsigned AB    = spe_pkg::ADDR_BITS_DEF;
  localparam int unsigned IXW   = spe_pkg::CFG_IDX_W;
  localparam int unsigned VW    = spe_pkg::CFG_W;
  localparam logic [63:0] AMASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - AB);
  localparam logic [63:0] LMASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - AB + LB);

  typedef struct {
    logic          func;
    logic [AB-1:0] addr;
    logic          hit;
    logic          iok;
    logic          mshr;
  } access_t;

  typedef struct {
    logic          valid;
    logic [AB-1:0] addr;
    logic          fill;
    logic          busy;
  } prefetch_t;

  class prefetch_scoreboard;
    logic [63:0] reg_start[NREG];
    logic [1:0]  reg_dir[NREG];
    logic [63:0] reg_stamp[NREG];
    logic [63:0] use_cnt, prev_line, look_addr;
    longint      prev_delta;
    logic [1:0]  prev_dir, look_dir;
    logic [7:0]  look_left, reg_len, deg;
    logic        cross_ok;
    prefetch_t   want_q[$];
    int          errors, n_checked, n_valid;

    function new();
      for (int i = 0; i < NREG; i++) begin
        reg_start[i] = '0;
        reg_dir[i] = spe_pkg::DIR_NONE;
        reg_stamp[i] = '0;
      end
      use_cnt = '0;
      prev_line = '0;
      look_addr = '0;
      prev_delta = 0;
      prev_dir = spe_pkg::DIR_NONE;
      look_dir = spe_pkg::DIR_NONE;
      look_left = '0;
      reg_len = spe_pkg::DIST_RST;
      deg = spe_pkg::DEG_RST;
      cross_ok = spe_pkg::CROSS_RST;
      errors = 0;
      n_checked = 0;
      n_valid = 0;
    endfunction

    function void set_reg(logic [IXW-1:0] idx, logic [VW-1:0] val);
      if (idx == spe_pkg::CFG_DIST) reg_len = val;
      else if (idx == spe_pkg::CFG_DEG) deg = val;
      else if (idx == spe_pkg::CFG_CROSS) cross_ok = val[0];
    endfunction

    function logic [63:0] slide(logic [63:0] base, logic [1:0] d, logic [63:0] amt);
      if (d == spe_pkg::DIR_UP) return base + amt;
      if (d == spe_pkg::DIR_DOWN) return base - amt;
      return base;
    endfunction

    function int region_lookup(logic [63:0] line);
      logic [63:0] s, e;
      for (int i = 0; i < NREG; i++) begin
        s = reg_start[i];
        e = s - 64'(reg_len);
        if ((reg_dir[i] == spe_pkg::DIR_UP && s <= line && line < s + 64'(reg_len)) ||
            (reg_dir[i] == spe_pkg::DIR_DOWN && s >= line && line > e)) begin
          use_cnt = use_cnt + 1;
          reg_stamp[i] = use_cnt;
          return i;
        end
      end
      return -1;
    endfunction

    function void region_insert(logic [63:0] start, logic [1:0] d);
      int victim;
      victim = 0;
      for (int i = 1; i < NREG; i++)
        if (reg_stamp[i] == 0 || reg_stamp[i] < reg_stamp[victim]) victim = i;
      use_cnt = use_cnt + 1;
      reg_stamp[victim] = use_cnt;
      reg_start[victim] = start & LMASK;
      reg_dir[victim] = d;
    endfunction

    function void train_miss(logic [63:0] line);
      int          h;
      longint      delta, span;
      logic [1:0]  d, rdir;
      logic [63:0] s;
      h = region_lookup(line);
      delta = longint'(line) - longint'(prev_line);
      d = delta > 0 ? spe_pkg::DIR_UP : (delta < 0 ? spe_pkg::DIR_DOWN : spe_pkg::DIR_NONE);
      span = delta + prev_delta;
      if (h >= 0) begin
        rdir = reg_dir[h];
        s = reg_start[h];
        look_addr = (slide(s, rdir, 64'(reg_len)) << LB) & AMASK;
        look_dir = rdir;
        look_left = deg;
        reg_start[h] = slide(s, rdir, 64'(deg)) & LMASK;
      end
      if (d == spe_pkg::DIR_UP && prev_dir == spe_pkg::DIR_UP && span < longint'(reg_len))
        region_insert(line - 64'(span), spe_pkg::DIR_UP);
      else if (d == spe_pkg::DIR_DOWN && prev_dir == spe_pkg::DIR_DOWN &&
               span + longint'(reg_len) > 0)
        region_insert(line - 64'(span), spe_pkg::DIR_DOWN);
      prev_line = line;
      prev_dir = d;
      prev_delta = delta;
    endfunction

    function void note_access(access_t a);
      prefetch_t   r;
      logic [63:0] pf;
      r.valid = 1'b0;
      r.addr = '0;
      r.fill = 1'b0;
      if (!a.func) begin
        if (!a.hit) train_miss((64'(a.addr) >> LB) & LMASK);
      end else if (look_left != 0) begin
        pf = slide(look_addr, look_dir, 64'(1) << LB) & AMASK;
        if (cross_ok || (pf >> PB) == (look_addr >> PB)) begin
          r.valid = 1'b1;
          r.addr = pf[AB-1:0];
          r.fill = a.mshr;
          if (a.iok) begin
            look_addr = pf;
            look_left = look_left - 1;
          end
        end else begin
          look_left = '0;
        end
      end
      r.busy = look_left != 0;
      want_q.push_back(r);
    endfunction

    function void check_result(prefetch_t got);
      prefetch_t w;
      n_checked++;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected item valid=%0b addr=%h", $realtime, got.valid, got.addr);
        errors++;
        return;
      end
      w = want_q.pop_front();
      if (got.valid) n_valid++;
      if (got.valid !== w.valid) begin
        $display("%0t: prefetch_valid expected %0b actual %0b", $realtime, w.valid, got.valid);
        errors++;
      end
      if (got.addr !== w.addr) begin
        $display("%0t: prefetch_addr expected %h actual %h", $realtime, w.addr, got.addr);
        errors++;
      end
      if (got.fill !== w.fill) begin
        $display("%0t: fill_this_level expected %0b actual %0b", $realtime, w.fill, got.fill);
        errors++;
      end
      if (got.busy !== w.busy) begin
        $display("%0t: lookahead_busy expected %0b actual %0b", $realtime, w.busy, got.busy);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i, rst_ni;
  logic                 cfg_we_i;
  logic [IXW-1:0]       cfg_idx_i;
  logic [VW-1:0]        cfg_wdata_i;
  logic                 push, full, empty, pop;
  logic                 func_i, cache_hit_i, issue_ok_i, mshr_below_half_i;
  logic [AB-1:0]        access_addr_i;
  logic                 prefetch_valid_o, fill_this_level_o, lookahead_busy_o;
  logic [AB-1:0]        prefetch_addr_o;

  prefetch_scoreboard sb;
  bit                 steady_send;
  int                 n_sent, n_miss, n_tick, n_configs;

  stream_prefetch_engine dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .push(push), .full(full),
    .func_i(func_i), .access_addr_i(access_addr_i), .cache_hit_i(cache_hit_i),
    .issue_ok_i(issue_ok_i), .mshr_below_half_i(mshr_below_half_i),
    .empty(empty), .pop(pop),
    .prefetch_valid_o(prefetch_valid_o), .prefetch_addr_o(prefetch_addr_o),
    .fill_this_level_o(fill_this_level_o), .lookahead_busy_o(lookahead_busy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(access_t a);
    int gap;
    push <= 1'b1;
    func_i <= a.func;
    access_addr_i <= a.addr;
    cache_hit_i <= a.hit;
    issue_ok_i <= a.iok;
    mshr_below_half_i <= a.mshr;
    do @(posedge clk_i); while (full);
    sb.note_access(a);
    n_sent++;
    if (a.func) n_tick++;
    else if (!a.hit) n_miss++;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_miss(logic [63:0] line);
    access_t a;
    a.func = 1'b0;
    a.addr = AB'((line << LB) | 64'($urandom_range(0, (1 << LB) - 1)));
    a.hit = 1'b0;
    a.iok = $urandom_range(0, 1);
    a.mshr = $urandom_range(0, 1);
    send(a);
  endtask

  task automatic send_tick(logic ok);
    access_t a;
    a.func = 1'b1;
    a.addr = AB'({$urandom, $urandom});
    a.hit = $urandom_range(0, 1);
    a.iok = ok;
    a.mshr = $urandom_range(0, 1);
    send(a);
  endtask

  task automatic write_reg(logic [IXW-1:0] idx, logic [VW-1:0] val);
    push <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (NREG + 10) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    n_configs++;
  endtask

  task automatic random_phase(int count);
    logic [63:0] line;
    int          stride, len, kind;
    access_t     a;
    for (int k = 0; k < count; ) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        case ($urandom_range(0, 3))
          0: line = 64'($urandom_range(0, 20));
          1: line = LMASK - 64'($urandom_range(0, 20));
          2: line = ({$urandom, $urandom} & LMASK) | 64'h3C;
          default: line = {$urandom, $urandom} & LMASK;
        endcase
        stride = $urandom_range(1, 3);
        len = $urandom_range(3, 8);
        for (int j = 0; j < len; j++) begin
          send_miss(line);
          k++;
          line = ($urandom_range(0, 1) ? line + 64'(stride) : line - 64'(stride)) & LMASK;
          if ($urandom_range(0, 2) != 0) line = (kind < 4) ? (line + 64'(2 * stride)) & LMASK
                                                            : (line - 64'(2 * stride)) & LMASK;
          repeat ($urandom_range(0, 3)) begin
            send_tick($urandom_range(0, 9) < 7);
            k++;
          end
        end
      end else if (kind < 9) begin
        repeat ($urandom_range(2, 12)) begin
          send_tick($urandom_range(0, 9) < 7);
          k++;
        end
      end else begin
        a.func = 1'b0;
        a.addr = AB'({$urandom, $urandom});
        a.hit = $urandom_range(0, 1);
        a.iok = $urandom_range(0, 1);
        a.mshr = $urandom_range(0, 1);
        send(a);
        k++;
      end
    end
  endtask

  // Receiver: random stalls, stretches with none, and one long hold-off.
  initial begin
    int stall, hold;
    bit held;
    prefetch_t r;
    pop <= 1'b0;
    held = 1'b0;
    stall = 0;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        r.valid = prefetch_valid_o;
        r.addr = prefetch_addr_o;
        r.fill = fill_this_level_o;
        r.busy = lookahead_busy_o;
        sb.check_result(r);
      end
      if (!held && sb.n_checked >= 300) begin
        held = 1'b1;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if ((sb.n_checked / 150) % 3 == 0) begin
        pop <= 1'b1;
      end else begin
        stall = pick_gap();
        pop <= (stall == 0);
      end
    end
  end

  initial begin
    sb = new();
    n_sent = 0;
    n_miss = 0;
    n_tick = 0;
    n_configs = 0;
    steady_send = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = spe_pkg::CFG_DIST;
    cfg_wdata_i = '0;
    func_i = 1'b0;
    access_addr_i = '0;
    cache_hit_i = 1'b0;
    issue_ok_i = 1'b0;
    mshr_below_half_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tick with no lookahead, address extremes, a cache hit,
    // streams near line zero, near the top line, and across a page end.
    send_tick(1'b1);
    send_miss(64'd0);
    send_miss(LMASK);
    begin
      access_t a;
      a.func = 1'b0; a.addr = '1; a.hit = 1'b1; a.iok = 1'b1; a.mshr = 1'b1;
      send(a);
    end
    send_miss(64'd2); send_miss(64'd1); send_miss(64'd0); send_miss(64'd1);
    send_miss(64'd0); send_miss(64'd1); send_miss(64'd2); send_miss(64'd3);
    repeat (3) send_tick(1'b1);
    send_miss(LMASK - 2); send_miss(LMASK - 1); send_miss(LMASK); send_miss(LMASK - 1);
    send_tick(1'b0);
    send_miss(64'h3A); send_miss(64'h3B); send_miss(64'h3C); send_miss(64'h3D);
    repeat (4) send_tick(1'b1);

    random_phase(200);
    write_reg(spe_pkg::CFG_CROSS, 8'd1);
    steady_send = 1'b1;
    random_phase(250);
    steady_send = 1'b0;
    write_reg(spe_pkg::CFG_DIST, 8'd1);
    write_reg(spe_pkg::CFG_DEG, 8'd1);
    random_phase(250);
    write_reg(spe_pkg::CFG_DIST, 8'd255);
    write_reg(spe_pkg::CFG_DEG, 8'd255);
    random_phase(250);
    write_reg(spe_pkg::CFG_CROSS, 8'd0);
    random_phase(250);
    write_reg(spe_pkg::CFG_DIST, VW'($urandom_range(2, 40)));
    write_reg(spe_pkg::CFG_DEG, VW'($urandom_range(2, 40)));
    random_phase(300);

    push <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (NREG + 10) @(posedge clk_i);
    $display("Sent %0d items (%0d training misses, %0d ticks) over %0d register writes.",
             n_sent, n_miss, n_tick, n_configs);
    $display("Checked %0d results, %0d of them prefetch attempts.", sb.n_checked, sb.n_valid);
    if (sb.errors == 0 && sb.want_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/spe_pkg.sv
rtl/core/spe_fifo.sv
rtl/core/spe_front.sv
rtl/core/spe_rtab.sv
rtl/core/spe_back.sv
rtl/core/stream_prefetch_engine.sv
sim/stream_prefetch_engine_tb.sv
